// ===== hdl/tgb_pkg.sv =====
// shared constants and types of the thresholded 3x3 gaussian blur
package tgb_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CORNER_W   = 2 * PIX_W + 2;
    localparam int CENTER_W   = 2 * PIX_W;
    localparam int SUM_W      = 2 * PIX_W + 4;

    localparam logic [PIX_W-1:0]    PIX_MAX        = 8'd255;
    localparam logic [WIDTH_W-1:0]  MIN_WIDTH      = 12'd3;
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_VAL  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT     = 16'd3;

    localparam logic [PIX_W-1:0]    LOW_CUT_RST    = 8'd100;
    localparam logic [PIX_W-1:0]    HIGH_CUT_RST   = 8'd160;
    localparam logic [PIX_W-1:0]    CORNER_WT_RST  = 8'd23;
    localparam logic [PIX_W-1:0]    EDGE_WT_RST    = 8'd31;
    localparam logic [PIX_W-1:0]    CENTER_WT_RST  = 8'd38;
    localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST = 12'd640;
    localparam logic [HEIGHT_W-1:0] FRAME_H_RST    = 16'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_CUT       = 3'd0,
        REG_HIGH_CUT      = 3'd1,
        REG_CORNER_WEIGHT = 3'd2,
        REG_EDGE_WEIGHT   = 3'd3,
        REG_CENTER_WEIGHT = 3'd4,
        REG_LINE_WIDTH    = 3'd5,
        REG_FRAME_HEIGHT  = 3'd6
    } cfg_index_t;

endpackage

// ===== hdl/tgb_if.sv =====
// stream interfaces for pixel beats in and blurred result beats out
interface tgb_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [tgb_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface tgb_result_if;
    logic                        valid;
    logic                        ready;
    logic [tgb_pkg::PIX_W-1:0]    blurred;
    logic [tgb_pkg::HEIGHT_W-1:0] out_row;
    logic [tgb_pkg::ADDR_W-1:0]   out_col;
    logic                        frame_end;

    modport source (output valid, output blurred, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink (input valid, input blurred, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

// ===== hdl/threshold_gaussian_blur_3x3_unit.sv =====
// top level: thresholded 3x3 gaussian blur over a raster pixel stream
//
// pixels: one grey pixel per beat in raster order, valid/ready handshake.
// results: one beat per interior pixel (row 1..H-2, col 1..W-2) with the
// blurred value, its row and column, and frame_end on the last one.
// border pixels are consumed and give no result beat.
// config: cfg_write with cfg_index/cfg_data sets one register per cycle;
// write only while no pixel is in flight.
// throughput: one pixel per cycle while no untaken result beat stalls;
// the line stores are single-write memories with one registered read,
// so each beat is constant work. the result for the window completed by
// a pixel passes the line store read, window, products and sum registers.
// stall: the four stages move together; while the result register holds an
// untaken beat, pixels.ready is low and the pipeline holds its contents.
// reset: registers take their reset values, counters and window clear,
// the line stores are not cleared and need no clearing pass.
module threshold_gaussian_blur_3x3_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    tgb_pixel_if.sink                        pixels,
    tgb_result_if.source                     results
);

    logic [tgb_pkg::PIX_W-1:0]    low_cut_reg;
    logic [tgb_pkg::PIX_W-1:0]    high_cut_reg;
    logic [tgb_pkg::PIX_W-1:0]    corner_weight_reg;
    logic [tgb_pkg::PIX_W-1:0]    edge_weight_reg;
    logic [tgb_pkg::PIX_W-1:0]    center_weight_reg;
    logic [tgb_pkg::WIDTH_W-1:0]  line_width_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] frame_height_reg;

    logic [tgb_pkg::WIDTH_W-1:0]  eff_width;
    logic [tgb_pkg::HEIGHT_W-1:0] eff_height;

    logic                         adv;
    logic                         accept;
    logic [tgb_pkg::PIX_W-1:0]    pix_clamped;

    logic [tgb_pkg::ADDR_W-1:0]   col_count_reg;
    logic [tgb_pkg::ADDR_W-1:0]   col_count_next;
    logic [tgb_pkg::HEIGHT_W-1:0] row_count_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] row_count_next;
    logic                         col_wrap;

    logic [tgb_pkg::PIX_W-1:0]    line_store_a_reg [tgb_pkg::MAX_WIDTH];
    logic [tgb_pkg::PIX_W-1:0]    line_store_b_reg [tgb_pkg::MAX_WIDTH];
    logic [tgb_pkg::PIX_W-1:0]    rd_a_reg;
    logic [tgb_pkg::PIX_W-1:0]    rd_b_reg;

    logic                         s1_valid_reg;
    logic [tgb_pkg::PIX_W-1:0]    s1_pix_reg;
    logic [tgb_pkg::ADDR_W-1:0]   s1_idx_reg;
    logic                         s1_emit_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] s1_row_reg;
    logic [tgb_pkg::ADDR_W-1:0]   s1_col_reg;
    logic                         s1_last_reg;

    logic [tgb_pkg::PIX_W-1:0]    win_reg [9];
    logic                         s2_valid_reg;
    logic                         s2_emit_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] s2_row_reg;
    logic [tgb_pkg::ADDR_W-1:0]   s2_col_reg;
    logic                         s2_last_reg;

    logic [tgb_pkg::PIX_W+1:0]    corner_sum;
    logic [tgb_pkg::PIX_W+1:0]    edge_sum;
    logic [tgb_pkg::CORNER_W-1:0] corner_prod_reg;
    logic [tgb_pkg::CORNER_W-1:0] edge_prod_reg;
    logic [tgb_pkg::CENTER_W-1:0] center_prod_reg;
    logic                         s3_valid_reg;
    logic                         s3_emit_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] s3_row_reg;
    logic [tgb_pkg::ADDR_W-1:0]   s3_col_reg;
    logic                         s3_last_reg;

    logic [tgb_pkg::SUM_W-1:0]    total;
    logic [tgb_pkg::PIX_W-1:0]    blurred_next;

    logic                         out_valid_reg;
    logic [tgb_pkg::PIX_W-1:0]    out_blurred_reg;
    logic [tgb_pkg::HEIGHT_W-1:0] out_row_reg;
    logic [tgb_pkg::ADDR_W-1:0]   out_col_reg;
    logic                         out_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cut_reg       <= tgb_pkg::LOW_CUT_RST;
            high_cut_reg      <= tgb_pkg::HIGH_CUT_RST;
            corner_weight_reg <= tgb_pkg::CORNER_WT_RST;
            edge_weight_reg   <= tgb_pkg::EDGE_WT_RST;
            center_weight_reg <= tgb_pkg::CENTER_WT_RST;
            line_width_reg    <= tgb_pkg::LINE_WIDTH_RST;
            frame_height_reg  <= tgb_pkg::FRAME_H_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tgb_pkg::REG_LOW_CUT:       low_cut_reg       <= cfg_data[tgb_pkg::PIX_W-1:0];
                tgb_pkg::REG_HIGH_CUT:      high_cut_reg      <= cfg_data[tgb_pkg::PIX_W-1:0];
                tgb_pkg::REG_CORNER_WEIGHT: corner_weight_reg <= cfg_data[tgb_pkg::PIX_W-1:0];
                tgb_pkg::REG_EDGE_WEIGHT:   edge_weight_reg   <= cfg_data[tgb_pkg::PIX_W-1:0];
                tgb_pkg::REG_CENTER_WEIGHT: center_weight_reg <= cfg_data[tgb_pkg::PIX_W-1:0];
                tgb_pkg::REG_LINE_WIDTH:    line_width_reg    <= cfg_data[tgb_pkg::WIDTH_W-1:0];
                tgb_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[tgb_pkg::HEIGHT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // clipped geometry
    always_comb
    begin
        if (line_width_reg < tgb_pkg::MIN_WIDTH)
            eff_width = tgb_pkg::MIN_WIDTH;
        else if (line_width_reg > tgb_pkg::MAX_WIDTH_VAL)
            eff_width = tgb_pkg::MAX_WIDTH_VAL;
        else
            eff_width = line_width_reg;
        eff_height = (frame_height_reg < tgb_pkg::MIN_HEIGHT) ? tgb_pkg::MIN_HEIGHT
                                                               : frame_height_reg;
    end

    assign adv          = !out_valid_reg || results.ready;
    assign pixels.ready = adv;
    assign accept       = pixels.valid && adv;

    // threshold clamp
    always_comb
    begin
        if (pixels.pixel < low_cut_reg)
            pix_clamped = '0;
        else if (pixels.pixel > high_cut_reg)
            pix_clamped = tgb_pkg::PIX_MAX;
        else
            pix_clamped = pixels.pixel;
    end

    // raster position
    always_comb
    begin
        col_wrap = ({1'b0, col_count_reg} + 12'd1) >= eff_width;
        if (col_wrap)
        begin
            col_count_next = '0;
            if (({1'b0, row_count_reg} + 17'd1) >= {1'b0, eff_height})
                row_count_next = '0;
            else
                row_count_next = row_count_reg + 16'd1;
        end
        else
        begin
            col_count_next = col_count_reg + 11'd1;
            row_count_next = row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // line stores: read on the beat, write back when the item reaches the window
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            line_store_a_reg[s1_idx_reg] <= s1_pix_reg;
        if (accept)
            rd_a_reg <= line_store_a_reg[col_count_reg];
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            line_store_b_reg[s1_idx_reg] <= rd_a_reg;
        if (accept)
            rd_b_reg <= line_store_b_reg[col_count_reg];
    end

    // stage valids and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pixels.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && s3_emit_reg;
        end
    end

    // 3x3 window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[2] <= rd_b_reg;
            win_reg[5] <= rd_a_reg;
            win_reg[8] <= s1_pix_reg;
        end
    end

    assign corner_sum = {2'b00, win_reg[0]} + {2'b00, win_reg[2]}
                      + {2'b00, win_reg[6]} + {2'b00, win_reg[8]};
    assign edge_sum   = {2'b00, win_reg[1]} + {2'b00, win_reg[3]}
                      + {2'b00, win_reg[5]} + {2'b00, win_reg[7]};

    assign total = {2'b00, corner_prod_reg} + {2'b00, edge_prod_reg}
                 + {4'b0000, center_prod_reg};

    always_comb
    begin
        if (total[tgb_pkg::SUM_W-1:tgb_pkg::PIX_W] > {4'b0000, tgb_pkg::PIX_MAX})
            blurred_next = tgb_pkg::PIX_MAX;
        else
            blurred_next = total[2*tgb_pkg::PIX_W-1:tgb_pkg::PIX_W];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix_clamped;
            s1_idx_reg  <= col_count_reg;
            s1_emit_reg <= (row_count_reg >= 16'd2) && (col_count_reg >= 11'd2);
            s1_row_reg  <= row_count_reg - 16'd1;
            s1_col_reg  <= col_count_reg - 11'd1;
            s1_last_reg <= (row_count_reg == eff_height - 16'd1)
                        && ({1'b0, col_count_reg} == eff_width - 12'd1);
        end
        if (adv)
        begin
            s2_emit_reg     <= s1_emit_reg;
            s2_row_reg      <= s1_row_reg;
            s2_col_reg      <= s1_col_reg;
            s2_last_reg     <= s1_last_reg;

            corner_prod_reg <= tgb_pkg::CORNER_W'(corner_weight_reg * corner_sum);
            edge_prod_reg   <= tgb_pkg::CORNER_W'(edge_weight_reg * edge_sum);
            center_prod_reg <= tgb_pkg::CENTER_W'(center_weight_reg * win_reg[4]);
            s3_emit_reg     <= s2_emit_reg;
            s3_row_reg      <= s2_row_reg;
            s3_col_reg      <= s2_col_reg;
            s3_last_reg     <= s2_last_reg;

            out_blurred_reg <= blurred_next;
            out_row_reg     <= s3_row_reg;
            out_col_reg     <= s3_col_reg;
            out_last_reg    <= s3_last_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.blurred   = out_blurred_reg;
    assign results.out_row   = out_row_reg;
    assign results.out_col   = out_col_reg;
    assign results.frame_end = out_last_reg;

`ifndef SYNTH
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_wrap) |=> (col_count_reg == '0))
        else $error("column counter did not wrap at line end");

    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_row_reg != '0) && (out_col_reg != '0))
        else $error("result beat on a border pixel");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg && s3_emit_reg && adv))
        else $error("result beat without an interior item in the last stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && s1_valid_reg) |=> s1_valid_reg && $stable(rd_a_reg) && $stable(rd_b_reg))
        else $error("line store read data lost during a stall");
`endif

endmodule
